// File: rtl/qcrf_pkg.sv
// Package for the quarter-circle radial fill block.
// Holds the field widths, default sizes, quadrant codes and the column-setup state type.
// Depends on nothing; every other file in rtl imports it.
package qcrf_pkg;

  // Default sizes, overridable through the top-level parameters.
  localparam int SAMPLES_PER_LINE = 1000;
  localparam int MAX_RADIUS       = 2047;

  // Fixed field widths of the request and point channels.
  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 11;
  localparam int QUAD_W   = 2;
  localparam int POINT_W  = 14;

  // Quadrant codes.
  localparam logic [QUAD_W-1:0] QUAD_UP_LEFT    = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_UP_RIGHT   = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_DOWN_RIGHT = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_DOWN_LEFT  = 2'd3;

  // States of the column-setup sequencer.
  typedef enum logic [2:0] {
    CP_IDLE,
    CP_SQUARE,
    CP_SETUP,
    CP_ROOT,
    CP_ROUND,
    CP_DIVIDE,
    CP_REDUCE,
    CP_DONE
  } cp_state_t;

endpackage

// File: rtl/quarter_circle_radial_fill.sv
// Top level of the quarter-circle radial fill: request decode, column registers, line
// walker control and the point output register. Uses qcrf_pkg, qcrf_colprep, qcrf_axis.
//
//   channel  direction  handshake          payload
//   in_*     input      in_valid/in_stall  start_req, center_x, center_y, radius, quadrant
//   out_*    output     out_valid/out_stall point_x, point_y, last_point
//
// A tick request makes one point, one per cycle while the input is not stalled, through a single output register.
// After a start request the first column is set up (RW = bits of MaxRadius): square,
// setup, RW root steps, round, divide, reduce; it is then loaded into the column
// registers, and ticks stall until it is loaded.
// Later columns are set up while the current column's 2*(N+1) points are drawn; a tick
// stalls only while the next column is not ready or the output is blocked. A start restarts the fill at once.
// Reset is synchronous, active low; it ends any running fill and empties the output.
module quarter_circle_radial_fill #(
  parameter int MaxRadius      = qcrf_pkg::MAX_RADIUS,
  parameter int SamplesPerLine = qcrf_pkg::SAMPLES_PER_LINE
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_start_req,
  input  logic [qcrf_pkg::COORD_W-1:0]          in_center_x,
  input  logic [qcrf_pkg::COORD_W-1:0]          in_center_y,
  input  logic [qcrf_pkg::RADIUS_W-1:0]         in_radius,
  input  logic [qcrf_pkg::QUAD_W-1:0]           in_quadrant,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qcrf_pkg::POINT_W-1:0]   out_point_x,
  output logic signed [qcrf_pkg::POINT_W-1:0]   out_point_y,
  output logic                                  out_last_point
);
  import qcrf_pkg::*;

  localparam int RW = $clog2(MaxRadius + 1);
  localparam int SW = $clog2(SamplesPerLine + 1);

  // Fill state.
  logic                active_r, cur_valid_r, line_r;
  logic [SW-1:0]       k_r;
  logic [COORD_W-1:0]  cx_r, cy_r;
  logic [RW-1:0]       rad_r;
  logic [QUAD_W-1:0]   quad_r;
  logic [RW-1:0]       prep_col_r;
  logic [RW-1:0]       hq_r, cq_r;
  logic [SW-1:0]       hr_r, cr_r;
  logic                final_r;

  // Output register.
  logic                       out_valid_r;
  logic signed [POINT_W-1:0]  out_x_r, out_y_r;
  logic                       out_last_r;

  logic                start_acc, tick_acc, line_end, col_end, load, prep_start;
  logic [RW-1:0]       sat_rad, prep_rad, prep_col;
  logic                prep_done, prep_final;
  logic [RW-1:0]       prep_hq, prep_cq;
  logic [SW-1:0]       prep_hr, prep_cr;
  logic [RW-1:0]       x_quo, y_quo;
  logic [SW-1:0]       x_rem, y_rem;
  logic                x_neg, y_neg, axis_clear;
  logic signed [POINT_W-1:0] pt_x, pt_y;

  // Request handshake: hold off while the output is blocked or the column is not ready.
  assign in_stall  = (out_valid_r && out_stall) || (active_r && !cur_valid_r);
  assign start_acc = in_valid && !in_stall && in_start_req;
  assign tick_acc  = in_valid && !in_stall && !in_start_req && active_r;

  assign line_end = (k_r == SW'(SamplesPerLine));
  assign col_end  = tick_acc && line_r && line_end;

  // Move the prepared column in when the current one is empty or just finishing.
  assign load = active_r && !start_acc && prep_done
                && (!cur_valid_r || col_end) && !(col_end && final_r);

  // Radius saturation and the setup unit's operands.
  always_comb begin
    if (13'(in_radius) > 13'(MaxRadius)) begin
      sat_rad = RW'(MaxRadius);
    end else begin
      sat_rad = RW'(in_radius);
    end
  end

  assign prep_start = start_acc || load;
  assign prep_rad   = start_acc ? sat_rad : rad_r;
  assign prep_col   = start_acc ? '0 : prep_col_r + RW'(1);

  qcrf_colprep #(
    .MaxRadius      (MaxRadius),
    .SamplesPerLine (SamplesPerLine)
  ) u_colprep (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (prep_start),
    .radius    (prep_rad),
    .column    (prep_col),
    .done      (prep_done),
    .final_col (prep_final),
    .h_quo     (prep_hq),
    .h_rem     (prep_hr),
    .c_quo     (prep_cq),
    .c_rem     (prep_cr)
  );

  // Line 0 ends at (h, c), line 1 at (c, h); signs come from the quadrant.
  assign x_quo = line_r ? cq_r : hq_r;
  assign x_rem = line_r ? cr_r : hr_r;
  assign y_quo = line_r ? hq_r : cq_r;
  assign y_rem = line_r ? hr_r : cr_r;
  assign x_neg = !(quad_r == QUAD_UP_RIGHT || quad_r == QUAD_DOWN_RIGHT);
  assign y_neg = !(quad_r == QUAD_DOWN_RIGHT || quad_r == QUAD_DOWN_LEFT);
  assign axis_clear = start_acc || (tick_acc && line_end);

  qcrf_axis #(
    .MaxRadius      (MaxRadius),
    .SamplesPerLine (SamplesPerLine)
  ) u_axis_x (
    .clk      (clk),
    .clear    (axis_clear),
    .advance  (tick_acc),
    .step_quo (x_quo),
    .step_rem (x_rem),
    .negative (x_neg),
    .center   (cx_r),
    .coord    (pt_x)
  );

  qcrf_axis #(
    .MaxRadius      (MaxRadius),
    .SamplesPerLine (SamplesPerLine)
  ) u_axis_y (
    .clk      (clk),
    .clear    (axis_clear),
    .advance  (tick_acc),
    .step_quo (y_quo),
    .step_rem (y_rem),
    .negative (y_neg),
    .center   (cy_r),
    .coord    (pt_y)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cur_valid_r <= 1'b0;
      line_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start_acc) begin
        active_r    <= 1'b1;
        cur_valid_r <= 1'b0;
        line_r      <= 1'b0;
        k_r         <= '0;
      end else begin
        if (tick_acc) begin
          if (line_end) begin
            k_r    <= '0;
            line_r <= !line_r;
          end else begin
            k_r <= k_r + SW'(1);
          end
        end
        if (col_end && final_r) begin
          active_r <= 1'b0;
        end
        if (load) begin
          cur_valid_r <= 1'b1;
        end else if (col_end) begin
          cur_valid_r <= 1'b0;
        end
      end
      if (tick_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, column and point payload registers.
  always_ff @(posedge clk) begin
    if (start_acc) begin
      cx_r       <= in_center_x;
      cy_r       <= in_center_y;
      rad_r      <= sat_rad;
      quad_r     <= in_quadrant;
      prep_col_r <= '0;
    end else if (load) begin
      prep_col_r <= prep_col;
    end
    if (load) begin
      hq_r    <= prep_hq;
      hr_r    <= prep_hr;
      cq_r    <= prep_cq;
      cr_r    <= prep_cr;
      final_r <= prep_final;
    end
    if (tick_acc) begin
      out_x_r    <= pt_x;
      out_y_r    <= pt_y;
      out_last_r <= final_r && line_r && line_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_last_point = out_last_r;

  // A point is only drawn from a loaded column.
  assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |-> cur_valid_r)
    else $error("radial fill: point drawn without a column");

  // The last column's last point ends the fill.
  assert property (@(posedge clk) disable iff (!rst_n)
    (col_end && final_r) |=> !active_r)
    else $error("radial fill: fill did not end after last point");

  // The sample index never passes the line length.
  assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= SW'(SamplesPerLine))
    else $error("radial fill: sample index out of range");

  // A column load never coincides with a restart.
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !start_acc && active_r)
    else $error("radial fill: column loaded outside a fill");

endmodule

// File: rtl/qcrf_colprep.sv
// Column setup unit: height = round(sqrt(r*r - c*c)) and the split of height and column
// into quotient and remainder by the sample count. Uses qcrf_pkg.
module qcrf_colprep #(
  parameter int MaxRadius      = qcrf_pkg::MAX_RADIUS,
  parameter int SamplesPerLine = qcrf_pkg::SAMPLES_PER_LINE
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [$clog2(MaxRadius+1)-1:0]         radius,
  input  logic [$clog2(MaxRadius+1)-1:0]         column,
  output logic                                   done,
  output logic                                   final_col,
  output logic [$clog2(MaxRadius+1)-1:0]         h_quo,
  output logic [$clog2(SamplesPerLine+1)-1:0]    h_rem,
  output logic [$clog2(MaxRadius+1)-1:0]         c_quo,
  output logic [$clog2(SamplesPerLine+1)-1:0]    c_rem
);
  import qcrf_pkg::*;

  localparam int RW = $clog2(MaxRadius + 1);
  localparam int SW = $clog2(SamplesPerLine + 1);
  localparam int CW = $clog2(RW + 1);
  localparam int LW = $clog2(SamplesPerLine);
  localparam int SH = RW + LW;
  localparam int MW = RW + 2;
  localparam int PW = RW + MW;
  localparam logic [SW:0] DIVISOR = (SW+1)'(SamplesPerLine);
  // Rounded-up reciprocal of the sample count; exact quotients for every value below 2^RW.
  localparam logic [MW-1:0] RECIP =
    MW'(((1 << SH) + SamplesPerLine - 1) / SamplesPerLine);

  cp_state_t         state_r, state_nxt;
  logic [RW-1:0]     rad_r, col_r;
  logic [2*RW-1:0]   rsq_r, csq_r, n_r;
  logic [RW-1:0]     root_r;
  logic [RW+1:0]     rem_r;
  logic [CW-1:0]     cnt_r;
  logic [RW-1:0]     dh_r, dc_r;
  logic [RW-1:0]     qh_r, qc_r;
  logic [SW-1:0]     ph_r, pc_r;
  logic              final_r;

  logic [RW+1:0]     rem_sh, trial;
  logic              root_bit, round_up;
  logic [PW-1:0]     h_mul, c_mul;
  logic [RW-1:0]     h_quo_w, c_quo_w;
  logic [RW+SW-1:0]  h_back, c_back;
  logic [RW-1:0]     h_left, c_left;

  // One result bit of the square root per cycle, two radicand bits brought in.
  assign rem_sh   = {rem_r[RW-1:0], n_r[2*RW-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign root_bit = (rem_sh >= trial);
  // Round half up: the remainder n - s*s exceeds s.
  assign round_up = (rem_r > {2'b00, root_r});

  // Quotient by the sample count through the reciprocal, one multiply per value.
  assign h_mul   = PW'(dh_r) * PW'(RECIP);
  assign c_mul   = PW'(dc_r) * PW'(RECIP);
  assign h_quo_w = RW'(h_mul >> SH);
  assign c_quo_w = RW'(c_mul >> SH);

  // Remainder: the dividend less quotient times the sample count.
  assign h_back = (RW+SW)'(qh_r) * (RW+SW)'(SamplesPerLine);
  assign c_back = (RW+SW)'(qc_r) * (RW+SW)'(SamplesPerLine);
  assign h_left = dh_r - RW'(h_back);
  assign c_left = dc_r - RW'(c_back);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (start) begin
      state_nxt = CP_SQUARE;
    end else begin
      unique case (state_r)
        CP_SQUARE: state_nxt = CP_SETUP;
        CP_SETUP:  state_nxt = CP_ROOT;
        CP_ROOT:   if (cnt_r == '0) state_nxt = CP_ROUND;
        CP_ROUND:  state_nxt = CP_DIVIDE;
        CP_DIVIDE: state_nxt = CP_REDUCE;
        CP_REDUCE: state_nxt = CP_DONE;
        CP_IDLE,
        CP_DONE:   state_nxt = state_r;
        default:   state_nxt = CP_IDLE;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    done = (state_r == CP_DONE);
  end

  assign final_col = final_r;
  assign h_quo     = qh_r;
  assign h_rem     = ph_r;
  assign c_quo     = qc_r;
  assign c_rem     = pc_r;

  // Datapath registers, stepped by the sequencer state.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radius;
      col_r <= column;
    end else begin
      unique case (state_r)
        CP_SQUARE: begin
          rsq_r <= (2*RW)'(rad_r) * (2*RW)'(rad_r);
          csq_r <= (2*RW)'(col_r) * (2*RW)'(col_r);
        end
        CP_SETUP: begin
          n_r     <= (rsq_r > csq_r) ? rsq_r - csq_r : '0;
          final_r <= !({csq_r, 1'b0} < {1'b0, rsq_r});
          root_r  <= '0;
          rem_r   <= '0;
          cnt_r   <= CW'(RW - 1);
        end
        CP_ROOT: begin
          rem_r  <= root_bit ? rem_sh - trial : rem_sh;
          root_r <= RW'({root_r, root_bit});
          n_r    <= n_r << 2;
          cnt_r  <= cnt_r - CW'(1);
        end
        CP_ROUND: begin
          dh_r <= round_up ? root_r + RW'(1) : root_r;
          dc_r <= col_r;
        end
        CP_DIVIDE: begin
          qh_r <= h_quo_w;
          qc_r <= c_quo_w;
        end
        CP_REDUCE: begin
          ph_r <= SW'(h_left);
          pc_r <= SW'(c_left);
        end
        default: begin
        end
      endcase
    end
  end

  // The iteration count never runs past the result width.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CP_ROOT) |-> (cnt_r < CW'(RW)))
    else $error("colprep: iteration count out of range");

  // The remainder step leads straight to done.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CP_REDUCE && !start) |=> done)
    else $error("colprep: division did not finish");

  // Finished remainders are below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ({1'b0, ph_r} < DIVISOR && {1'b0, pc_r} < DIVISOR))
    else $error("colprep: remainder not reduced");

endmodule

// File: rtl/qcrf_axis.sv
// One axis of the radial line walker: exact offset d*k/N kept as quotient and remainder,
// stepped once per point, and the truncated coordinate. Uses qcrf_pkg.
module qcrf_axis #(
  parameter int MaxRadius      = qcrf_pkg::MAX_RADIUS,
  parameter int SamplesPerLine = qcrf_pkg::SAMPLES_PER_LINE
) (
  input  logic                                      clk,
  input  logic                                      clear,
  input  logic                                      advance,
  input  logic [$clog2(MaxRadius+1)-1:0]            step_quo,
  input  logic [$clog2(SamplesPerLine+1)-1:0]       step_rem,
  input  logic                                      negative,
  input  logic [qcrf_pkg::COORD_W-1:0]              center,
  output logic signed [qcrf_pkg::POINT_W-1:0]       coord
);
  import qcrf_pkg::*;

  localparam int RW = $clog2(MaxRadius + 1);
  localparam int SW = $clog2(SamplesPerLine + 1);
  localparam logic [SW:0] DIVISOR = (SW+1)'(SamplesPerLine);

  logic [RW-1:0]      acc_quo_r;
  logic [SW-1:0]      acc_rem_r;
  logic [SW:0]        rem_sum;
  logic               wrap;
  logic [POINT_W-1:0] cen_w, quo_w;
  logic               adj;

  // Remainder stays below N, so one compare and subtract carries it.
  assign rem_sum = {1'b0, acc_rem_r} + {1'b0, step_rem};
  assign wrap    = (rem_sum >= DIVISOR);

  always_ff @(posedge clk) begin
    if (clear) begin
      acc_quo_r <= '0;
      acc_rem_r <= '0;
    end else if (advance) begin
      acc_quo_r <= acc_quo_r + step_quo + RW'(wrap);
      acc_rem_r <= wrap ? SW'(rem_sum - DIVISOR) : SW'(rem_sum);
    end
  end

  // Toward-zero truncation: a negative direction with a fraction left drops one more
  // unit only while the point is still on the positive side of zero.
  assign cen_w = POINT_W'(center);
  assign quo_w = POINT_W'(acc_quo_r);
  assign adj   = (acc_rem_r != '0) && (cen_w > quo_w);

  always_comb begin
    if (negative) begin
      coord = signed'(cen_w - quo_w - POINT_W'(adj));
    end else begin
      coord = signed'(cen_w + quo_w);
    end
  end

endmodule

// File: tb/radial_fill_checker.sv
// Scoreboard for the quarter-circle radial fill: predicts every point from the accepted
// requests and compares it, field by field, with the points that leave the block.
// Depends on qcrf_pkg for the field widths, the fill sizes and the quadrant codes.
module radial_fill_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_start_req,
  input  logic [qcrf_pkg::COORD_W-1:0]        in_center_x,
  input  logic [qcrf_pkg::COORD_W-1:0]        in_center_y,
  input  logic [qcrf_pkg::RADIUS_W-1:0]       in_radius,
  input  logic [qcrf_pkg::QUAD_W-1:0]         in_quadrant,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [qcrf_pkg::POINT_W-1:0] out_point_x,
  input  logic signed [qcrf_pkg::POINT_W-1:0] out_point_y,
  input  logic                                out_last_point,
  output int                                  mismatches,
  output int                                  pending_points
);
  import qcrf_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic                      last;
  } fill_point_t;

  // Points predicted but not yet seen at the output, oldest first.
  fill_point_t expected_points[$];
  int          error_count = 0;

  // Our own copy of the fill state.
  bit                  fill_on;
  logic [COORD_W-1:0]  org_x;
  logic [COORD_W-1:0]  org_y;
  logic [RADIUS_W-1:0] fill_r;
  logic [QUAD_W-1:0]   fill_q;
  logic [RADIUS_W-1:0] col_idx;
  logic [RADIUS_W-1:0] col_h;
  bit                  second_line;
  int                  k_idx;

  // Column height: the square root of r*r - c*c, rounded half away from zero.
  function automatic int unsigned rounded_height(int unsigned r, int unsigned c);
    int unsigned n;
    int unsigned s;
    int unsigned trial;
    if (c >= r) begin
      return 0;
    end
    n = r * r - c * c;
    s = 0;
    for (int b = RADIUS_W; b >= 0; b--) begin
      trial = s | (32'd1 << b);
      if (trial * trial <= n) begin
        s = trial;
      end
    end
    // n above s*s + s means the exact root lies beyond s + 0.5.
    if (n > s * s + s) begin
      s++;
    end
    return s;
  endfunction

  // One coordinate of sample k on a line: the whole value truncated toward zero.
  function automatic longint line_coord(longint base, longint span, longint k);
    return (base * SAMPLES_PER_LINE + span * k) / SAMPLES_PER_LINE;
  endfunction

  // Apply one accepted request to the fill state; a tick in a running fill adds a point.
  task automatic advance_fill(input logic start, input logic [COORD_W-1:0] cx,
                              input logic [COORD_W-1:0] cy, input logic [RADIUS_W-1:0] r,
                              input logic [QUAD_W-1:0] q);
    longint      dir_x;
    longint      dir_y;
    longint      span_x;
    longint      span_y;
    longint      px;
    longint      py;
    bit          last_column;
    fill_point_t pt;
    if (start) begin
      org_x       = cx;
      org_y       = cy;
      fill_r      = (int'(r) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : r;
      fill_q      = q;
      col_idx     = '0;
      col_h       = RADIUS_W'(rounded_height(fill_r, 0));
      second_line = 1'b0;
      k_idx       = 0;
      fill_on     = 1'b1;
    end else if (fill_on) begin
      dir_x  = (fill_q == QUAD_UP_RIGHT || fill_q == QUAD_DOWN_RIGHT) ? 1 : -1;
      dir_y  = (fill_q == QUAD_DOWN_RIGHT || fill_q == QUAD_DOWN_LEFT) ? 1 : -1;
      span_x = dir_x * (second_line ? longint'(col_idx) : longint'(col_h));
      span_y = dir_y * (second_line ? longint'(col_h) : longint'(col_idx));
      px     = line_coord(longint'(org_x), span_x, longint'(k_idx));
      py     = line_coord(longint'(org_y), span_y, longint'(k_idx));
      last_column = !(2 * longint'(col_idx) * longint'(col_idx) <
                      longint'(fill_r) * longint'(fill_r));
      pt.x    = px[POINT_W-1:0];
      pt.y    = py[POINT_W-1:0];
      pt.last = last_column && second_line && (k_idx >= SAMPLES_PER_LINE);
      expected_points.push_back(pt);

      // Step to the next sample, then the second line, then the next column.
      k_idx++;
      if (k_idx > SAMPLES_PER_LINE) begin
        k_idx = 0;
        if (!second_line) begin
          second_line = 1'b1;
        end else begin
          second_line = 1'b0;
          if (last_column) begin
            fill_on = 1'b0;
          end else begin
            col_idx++;
            col_h = RADIUS_W'(rounded_height(fill_r, col_idx));
          end
        end
      end
    end
  endtask

  // Compare one accepted point with the oldest prediction.
  task automatic check_point();
    fill_point_t want;
    if (expected_points.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("radial fill: point x=%0d y=%0d last=%0d arrived with nothing expected",
                 out_point_x, out_point_y, out_last_point);
      end
    end else begin
      want = expected_points.pop_front();
      if (want.x !== out_point_x || want.y !== out_point_y || want.last !== out_last_point)
      begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("radial fill: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                   want.x, want.y, want.last, out_point_x, out_point_y, out_last_point);
        end
      end
    end
  endtask

  // Watch both channels at the rising edge; counts reach the top after the edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_on     = 1'b0;
      org_x       = '0;
      org_y       = '0;
      fill_r      = '0;
      fill_q      = QUAD_UP_LEFT;
      col_idx     = '0;
      col_h       = '0;
      second_line = 1'b0;
      k_idx       = 0;
      expected_points.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        advance_fill(in_start_req, in_center_x, in_center_y, in_radius, in_quadrant);
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        check_point();
      end
    end
    pending_points <= expected_points.size();
    mismatches     <= error_count;
  end

endmodule

// File: tb/tb_top.sv
// Top of the quarter-circle radial fill testbench: clock, reset, request and point traffic,
// a watchdog and the verdict. Depends on qcrf_pkg, quarter_circle_radial_fill and
// radial_fill_checker.
module tb_top;
  import qcrf_pkg::*;

  localparam int PERIOD       = 12;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_GAP      = 19;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_start_req;
  logic [COORD_W-1:0]        in_center_x;
  logic [COORD_W-1:0]        in_center_y;
  logic [RADIUS_W-1:0]       in_radius;
  logic [QUAD_W-1:0]         in_quadrant;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [POINT_W-1:0] out_point_x;
  logic signed [POINT_W-1:0] out_point_y;
  logic                      out_last_point;

  int mismatches;
  int pending_points;
  int quiet_cycles = 0;
  int requests_sent = 0;
  bit send_busy = 1'b0;
  bit hold_requested = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  quarter_circle_radial_fill dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_quadrant    (in_quadrant),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

  radial_fill_checker fill_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_quadrant    (in_quadrant),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .mismatches     (mismatches),
    .pending_points (pending_points)
  );

  // Watchdog: too long without any handshake on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Radius mix: many tiny ones, some at the top, the rest spread over the range.
  function automatic logic [RADIUS_W-1:0] pick_radius();
    case ($urandom_range(0, 7))
      0, 1:    return RADIUS_W'($urandom_range(0, 3));
      2:       return RADIUS_W'(MAX_RADIUS);
      default: return RADIUS_W'($urandom_range(0, (1 << RADIUS_W) - 1));
    endcase
  endfunction

  // Offer one request after a random gap and hold it until the block takes it.
  task automatic offer_request(input logic start, input logic [COORD_W-1:0] cx,
                               input logic [COORD_W-1:0] cy, input logic [RADIUS_W-1:0] r,
                               input logic [QUAD_W-1:0] q);
    int gap;
    gap = send_busy ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_center_x  <= cx;
    in_center_y  <= cy;
    in_radius    <= r;
    in_quadrant  <= q;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
  endtask

  // Start a fill with a random center and quadrant.
  task automatic start_fill(input logic [RADIUS_W-1:0] r);
    offer_request(1'b1, COORD_W'($urandom), COORD_W'($urandom), r, QUAD_W'($urandom));
  endtask

  // Ticks carry random payload, which the block must ignore.
  task automatic send_ticks(input int count);
    repeat (count) begin
      offer_request(1'b0, COORD_W'($urandom), COORD_W'($urandom), RADIUS_W'($urandom),
                    QUAD_W'($urandom));
    end
  endtask

  // Drop valid and wait until every predicted point has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points != 0);
  endtask

  // Point sink: random back-pressure, runs of none, and one long hold on request.
  initial begin : point_sink
    int  hold;
    bit  sink_busy;
    out_stall = 1'b0;
    sink_busy = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        sink_busy = !sink_busy;
      end
      hold = sink_busy ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_requested) begin
        hold_requested = 1'b0;
        hold = LONG_HOLD;
      end
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Request source and verdict.
  initial begin : request_source
    int run_idx;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    in_center_x  = '0;
    in_center_y  = '0;
    in_radius    = '0;
    in_quadrant  = QUAD_UP_LEFT;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a tick with no fill running, corner centers with the largest radius in two
    // quadrants, a restart in the middle of a fill, back-to-back starts and radius
    // zero, where every point is the center itself.
    offer_request(1'b0, '0, '0, '0, QUAD_UP_LEFT);
    offer_request(1'b1, '0, '0, RADIUS_W'(MAX_RADIUS), QUAD_UP_LEFT);
    send_ticks(3);
    offer_request(1'b1, '1, '1, RADIUS_W'(MAX_RADIUS), QUAD_DOWN_RIGHT);
    send_ticks(3);
    offer_request(1'b1, '1, '0, RADIUS_W'(1), QUAD_UP_RIGHT);
    send_ticks(2);
    offer_request(1'b1, '0, '1, RADIUS_W'(0), QUAD_DOWN_LEFT);
    offer_request(1'b1, '0, '1, '1, QUAD_DOWN_LEFT);
    offer_request(1'b1, COORD_W'(2048), COORD_W'(2047), RADIUS_W'(0), QUAD_UP_RIGHT);
    send_ticks(3);
    wait_drained();

    // Random fills cut short by the next start request, one of them under a long
    // output hold so that the block backs up and stalls its input.
    requests_sent = 0;
    run_idx = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      send_busy = ($urandom_range(0, 3) == 0);
      if (run_idx == 6) begin
        hold_requested = 1'b1;
        send_busy = 1'b1;
        start_fill(pick_radius());
        send_ticks(80);
      end else begin
        start_fill(pick_radius());
        send_ticks($urandom_range(0, 120));
      end
      run_idx++;
    end
    wait_drained();

    // Let the output sit idle to catch any stray point, then give the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_points == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/qcrf_pkg.sv
rtl/qcrf_colprep.sv
rtl/qcrf_axis.sv
rtl/quarter_circle_radial_fill.sv
tb/radial_fill_checker.sv
tb/tb_top.sv
